// File: sv/diamond_square_heightmap_assert.svh
// Assertion macros for the height map block
`ifndef DIAMOND_SQUARE_HEIGHTMAP_ASSERT_SVH
`define DIAMOND_SQUARE_HEIGHTMAP_ASSERT_SVH

`define DSH_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define DSH_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/dsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_pkg
// Shared types and constants for the diamond-square height map.
// ----------------------------------------------------------------------------
package dsh_pkg;
    localparam int GRID_LOG2 = 8;
    localparam int SIDE      = 1 << GRID_LOG2;
    localparam int AW        = 2 * GRID_LOG2;
    localparam int HW        = 24;

    localparam logic [0:0] CMD_GENERATE = 1'b0;
    localparam logic [0:0] CMD_READ     = 1'b1;

    localparam logic [0:0] REG_SEED  = 1'b0;
    localparam logic [0:0] REG_DECAY = 1'b1;

    // operations the controller asks of the datapath
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_INIT   = 4'd1,  // load seed, amplitude, clear flag, zero corner
        OP_RDADDR = 4'd2,  // issue memory read for neighbor k
        OP_LATCH  = 4'd3,  // capture read data into neighbor k
        OP_SUM    = 4'd4,  // add the four neighbors, step random
        OP_MUL    = 4'd5,  // random * span
        OP_WRITE  = 4'd6,  // saturate and write cell
        OP_DECAY  = 4'd7,  // amplitude *= decay
        OP_RDCELL = 4'd8   // read one cell for a read command
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [1:0]        nb;
        logic [AW-1:0]     addr;
    } dp_cmd_t;

    typedef struct packed {
        logic [HW-1:0] rdata;
        logic          clip;
    } dp_stat_t;
endpackage

// File: sv/diamond_square_heightmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diamond_square_heightmap
// Generates a wrapped diamond-square height map and serves cell reads.
// ----------------------------------------------------------------------------
// Generate: per displaced cell, four reads (address, wait, latch each), then
//   sum, multiply, write, over S*S-1 cells, plus init and a decay step per
//   level; the reads are serial, set by the one memory port.
// Read: cell read in S_RD, result registered in S_RDW, then valid. One request at a time.
// Reset: synchronous active low; clears control, generator and flags.
module diamond_square_heightmap (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_cell_x,
    input  logic [7:0]  s_cell_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [23:0] m_height,
    output logic        m_generate_done,
    output logic        m_saturated
);
    import dsh_pkg::*;

    logic [31:0] seed_reg;
    logic [15:0] decay_reg;
    dp_cmd_t cmd;
    dp_stat_t stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg  <= 32'd1;
            decay_reg <= 16'd32768;
        end else begin
            if (cfg_we && cfg_index == REG_SEED)  seed_reg  <= cfg_data;
            if (cfg_we && cfg_index == REG_DECAY) decay_reg <= cfg_data[15:0];
        end
    end

    dsh_control u_ctl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_command, .s_cell_x, .s_cell_z,
        .m_valid, .m_ready, .m_height, .m_generate_done, .m_saturated,
        .cmd, .stat
    );

    dsh_datapath u_dp (
        .aclk, .aresetn, .seed(seed_reg), .decay(decay_reg), .cmd(cmd), .stat
    );
endmodule

// File: sv/dsh_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_datapath
// Height memory, xorshift generator, amplitude and displacement arithmetic.
// ----------------------------------------------------------------------------
module dsh_datapath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [31:0]       seed,
    input  logic [15:0]       decay,
    input  dsh_pkg::dp_cmd_t  cmd,
    output dsh_pkg::dp_stat_t stat
);
    import dsh_pkg::*;

    logic signed [HW-1:0] mem [0:SIDE*SIDE-1];
    logic signed [HW-1:0] rd_reg;
    logic signed [HW-1:0] nb_reg [0:3];
    logic signed [HW+1:0] sum_reg;
    logic [31:0]          rnd_reg;
    logic [HW-1:0]        amp_reg;
    logic [56:0]          prod_reg;
    logic                 clip_reg;

    logic [31:0] x1, x2, x3;
    logic [HW:0] span;
    logic signed [HW+1:0] mean, pick, val;
    logic signed [HW-1:0] sat;
    logic [39:0] amp_prod;
    logic hi_c, lo_c;

    always_comb begin
        x1 = rnd_reg ^ (rnd_reg << 13);
        x2 = x1 ^ (x1 >> 17);
        x3 = x2 ^ (x2 << 5);
        span = {amp_reg, 1'b1};
        // floor division of the sum by four
        mean = sum_reg >>> 2;
        // product high word is below span, so it fits in 25 bits
        pick = $signed({1'b0, prod_reg[56:32]}) - $signed({2'b00, amp_reg});
        val  = mean + pick;
        hi_c = val > $signed(26'(2**23 - 1));
        lo_c = val < -$signed(26'(2**23));
        sat  = hi_c ? 24'sh7FFFFF : (lo_c ? 24'sh800000 : val[HW-1:0]);
        amp_prod = amp_reg * decay;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_reg  <= 32'd1;
            amp_reg  <= '0;
            clip_reg <= 1'b0;
        end else begin
            case (cmd.op)
                OP_INIT: begin
                    rnd_reg  <= (seed != 32'd0) ? seed : 32'd1;
                    amp_reg  <= HW'((SIDE >> 1) << 12);
                    clip_reg <= 1'b0;
                end
                OP_SUM:   rnd_reg  <= x3;
                OP_WRITE: if (hi_c || lo_c) clip_reg <= 1'b1;
                OP_DECAY: amp_reg  <= amp_prod[39:16];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_INIT:  mem[cmd.addr] <= '0;
            OP_WRITE: mem[cmd.addr] <= sat;
            default:  rd_reg <= mem[cmd.addr];
        endcase
        if (cmd.op == OP_LATCH) nb_reg[cmd.nb] <= rd_reg;
        if (cmd.op == OP_SUM)
            sum_reg <= 26'(nb_reg[0]) + 26'(nb_reg[1]) + 26'(nb_reg[2]) + 26'(nb_reg[3]);
        if (cmd.op == OP_MUL) prod_reg <= rnd_reg * 57'(span);
    end

    assign stat.rdata = rd_reg;
    assign stat.clip  = clip_reg;
endmodule

// File: sv/dsh_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_control
// Sequencer over levels, passes and cells; drives the datapath and handshake.
// ----------------------------------------------------------------------------
module dsh_control (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_command,
    input  logic [7:0]        s_cell_x,
    input  logic [7:0]        s_cell_z,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [23:0]       m_height,
    output logic              m_generate_done,
    output logic              m_saturated,
    output dsh_pkg::dp_cmd_t  cmd,
    input  dsh_pkg::dp_stat_t stat
);
    import dsh_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_INIT  = 11'b00000000010,
        S_ADDR  = 11'b00000000100,
        S_WAIT  = 11'b00000001000,
        S_LATCH = 11'b00000010000,
        S_SUM   = 11'b00000100000,
        S_MUL   = 11'b00001000000,
        S_WRITE = 11'b00010000000,
        S_RD    = 11'b00100000000,
        S_RDW   = 11'b01000000000,
        S_DECAY = 11'b10000000000
    } state_t;

    localparam int LW = $clog2(GRID_LOG2 + 1);

    state_t state_reg, state_next;
    logic [LW-1:0] lvl_reg;   // log2 of rectangle size
    logic [1:0] pass_reg;     // 0 diamond, 1 square left, 2 square top
    logic [GRID_LOG2-1:0] x_reg, z_reg;
    logic [1:0] k_reg;
    logic [GRID_LOG2-1:0] rx_reg, rz_reg;
    logic out_v_reg, out_g_reg;
    logic [HW-1:0] out_h_reg;

    logic [GRID_LOG2:0] r_full;
    logic [GRID_LOG2-1:0] r, h, nx, nz, mx, mz, px, pz, ax, az, wx, wz, xs, zs;
    logic last_cell;
    logic out_set;

    always_comb begin
        r_full = (GRID_LOG2+1)'(1) << lvl_reg;
        r  = r_full[GRID_LOG2-1:0];
        h  = r_full[GRID_LOG2:1];
        nx = x_reg + r; nz = z_reg + r;
        mx = x_reg + h; mz = z_reg + h;
        px = x_reg - h; pz = z_reg - h;
        ax = x_reg; az = z_reg;
        wx = mx; wz = mz;
        case (pass_reg)
            2'd0: begin
                case (k_reg)
                    2'd0: begin ax = x_reg; az = z_reg; end
                    2'd1: begin ax = nx; az = z_reg; end
                    2'd2: begin ax = x_reg; az = nz; end
                    default: begin ax = nx; az = nz; end
                endcase
            end
            2'd1: begin
                wx = x_reg; wz = mz;
                case (k_reg)
                    2'd0: begin ax = x_reg; az = z_reg; end
                    2'd1: begin ax = x_reg; az = nz; end
                    2'd2: begin ax = px; az = mz; end
                    default: begin ax = mx; az = mz; end
                endcase
            end
            default: begin
                wx = mx; wz = z_reg;
                case (k_reg)
                    2'd0: begin ax = x_reg; az = z_reg; end
                    2'd1: begin ax = nx; az = z_reg; end
                    2'd2: begin ax = mx; az = mz; end
                    default: begin ax = mx; az = pz; end
                endcase
            end
        endcase
        xs = x_reg + r;
        zs = z_reg + r;
        last_cell = (xs == '0) && (zs == '0);
    end

    assign s_ready = (state_reg == S_IDLE) && (!out_v_reg || m_ready);
    assign m_valid = out_v_reg;
    assign m_height = out_h_reg;
    assign m_generate_done = out_g_reg;
    assign m_saturated = stat.clip;

    always_comb begin
        state_next = state_reg;
        cmd.op = OP_NONE;
        cmd.nb = k_reg;
        cmd.addr = {az, ax};
        case (state_reg)
            S_IDLE: if (s_valid && s_ready)
                state_next = (s_command == CMD_READ) ? S_RD : S_INIT;
            S_INIT: begin
                cmd.op = OP_INIT; cmd.addr = '0; state_next = S_ADDR;
            end
            S_ADDR:  begin cmd.op = OP_RDADDR; state_next = S_WAIT; end
            S_WAIT:  state_next = S_LATCH;
            S_LATCH: begin
                cmd.op = OP_LATCH;
                state_next = (k_reg == 2'd3) ? S_SUM : S_ADDR;
            end
            S_SUM:   begin cmd.op = OP_SUM; state_next = S_MUL; end
            S_MUL:   begin cmd.op = OP_MUL; state_next = S_WRITE; end
            S_WRITE: begin
                cmd.op = OP_WRITE; cmd.addr = {wz, wx};
                state_next = S_ADDR;
                if (pass_reg == 2'd2 && last_cell) state_next = S_DECAY;
            end
            // level count is already decremented here
            S_DECAY: begin
                cmd.op = OP_DECAY;
                state_next = (lvl_reg == '0) ? S_IDLE : S_ADDR;
            end
            S_RD: begin
                cmd.op = OP_RDCELL; cmd.addr = {rz_reg, rx_reg}; state_next = S_RDW;
            end
            S_RDW: begin cmd.addr = {rz_reg, rx_reg}; state_next = S_IDLE; end
            default: state_next = S_IDLE;
        endcase
        out_set = (state_reg == S_RDW) || (state_reg == S_DECAY && lvl_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_set) out_v_reg <= 1'b1;
            else if (m_valid && m_ready) out_v_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (s_valid && s_ready) begin
                    rx_reg <= s_cell_x[GRID_LOG2-1:0];
                    rz_reg <= s_cell_z[GRID_LOG2-1:0];
                end
                S_INIT: begin
                    lvl_reg <= LW'(GRID_LOG2); pass_reg <= 2'd0;
                    x_reg <= '0; z_reg <= '0; k_reg <= '0;
                end
                S_LATCH: k_reg <= k_reg + 2'd1;
                S_WRITE: begin
                    k_reg <= '0;
                    if (pass_reg == 2'd1) pass_reg <= 2'd2;
                    else begin
                        if (pass_reg == 2'd2) pass_reg <= 2'd1;
                        x_reg <= xs;
                        if (xs == '0) z_reg <= zs;
                        if (last_cell) begin
                            pass_reg <= (pass_reg == 2'd0) ? 2'd1 : 2'd0;
                            if (pass_reg == 2'd2) lvl_reg <= lvl_reg - LW'(1);
                        end
                    end
                end
                S_DECAY: if (lvl_reg == '0) begin
                    out_g_reg <= 1'b1;
                    out_h_reg <= '0;
                end
                S_RDW: begin
                    out_g_reg <= 1'b0; out_h_reg <= stat.rdata;
                end
                default: ;
            endcase
        end
    end
endmodule

// File: sv/dsh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_checker
// Port-level checks for the height map block.
// ----------------------------------------------------------------------------
`include "diamond_square_heightmap_assert.svh"
module dsh_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_generate_done,
    input logic signed [23:0] m_height
);
    `DSH_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `DSH_ASSERT_IMPL(a_gen_zero, aclk, aresetn, m_valid && m_generate_done, m_height == 24'sd0)
    `DSH_ASSERT_NEXT(a_one_at_time, aclk, aresetn, s_valid && s_ready, !s_ready)
endmodule

bind diamond_square_heightmap dsh_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_generate_done, .m_height
);

// File: tb/sv/diamond_square_heightmap_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diamond_square_heightmap_test
// Self-checking bench: generates maps under several seed and decay settings,
// reads back cells and compares every result against a local map predictor.
// ----------------------------------------------------------------------------
module diamond_square_heightmap_test;
    import dsh_pkg::*;

    localparam int SMASK    = SIDE - 1;
    localparam int HMAX     = 8388607;
    localparam int HMIN     = -8388608;
    localparam int WD_LIMIT = 5000000;

    typedef struct {
        logic signed [23:0] height;
        logic               done;
        logic               sat;
    } height_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = REG_SEED;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = CMD_READ;
    logic [7:0]  s_cell_x = '0;
    logic [7:0]  s_cell_z = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic signed [23:0] m_height;
    logic        m_generate_done;
    logic        m_saturated;

    diamond_square_heightmap dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_command(s_command),
        .s_cell_x(s_cell_x), .s_cell_z(s_cell_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_height(m_height),
        .m_generate_done(m_generate_done), .m_saturated(m_saturated)
    );

    // predictor state
    int             map_cells [SIDE*SIDE];
    bit [31:0]      seed_reg = 32'd1;
    bit [15:0]      decay_reg = 16'd32768;
    bit [31:0]      rng;
    longint         amp = 0;
    bit             clip = 1'b0;
    height_result_t pending_results[$];

    int  errors = 0;
    int  stall_left = 0;
    bit  quiet = 1'b0;
    int  idle_count = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int cell_idx(int x, int z);
        return ((z & SMASK) << GRID_LOG2) | (x & SMASK);
    endfunction

    function automatic int next_offset();
        bit [63:0] pick;
        rng ^= rng << 13;
        rng ^= rng >> 17;
        rng ^= rng << 5;
        pick = ({32'd0, rng} * (2 * amp + 1)) >> 32;
        return int'(longint'(pick) - amp);
    endfunction

    function automatic int displace(int a, int b, int c, int d);
        int sum;
        int mean;
        int v;
        sum = a + b + c + d;
        mean = (sum >= 0) ? sum / 4 : -((-sum + 3) / 4);
        v = mean + next_offset();
        if (v > HMAX) begin
            v = HMAX;
            clip = 1'b1;
        end
        if (v < HMIN) begin
            v = HMIN;
            clip = 1'b1;
        end
        return v;
    endfunction

    function automatic void build_map();
        int r, h, x, z, nx, nz, mx, mz, px, pz, corner, centre, lft, top;
        rng  = (seed_reg != 0) ? seed_reg : 32'd1;
        clip = 1'b0;
        amp  = (SIDE >> 1) << 12;
        map_cells[0] = 0;
        for (r = SIDE; r >= 2; r >>= 1) begin
            h = r >> 1;
            for (z = 0; z < SIDE; z += r)
                for (x = 0; x < SIDE; x += r) begin
                    nx = (x + r) & SMASK;
                    nz = (z + r) & SMASK;
                    map_cells[cell_idx(x + h, z + h)] =
                        displace(map_cells[cell_idx(x, z)], map_cells[cell_idx(nx, z)],
                                 map_cells[cell_idx(x, nz)], map_cells[cell_idx(nx, nz)]);
                end
            for (z = 0; z < SIDE; z += r)
                for (x = 0; x < SIDE; x += r) begin
                    nx = (x + r) & SMASK;
                    nz = (z + r) & SMASK;
                    mx = x + h;
                    mz = z + h;
                    px = (x + SIDE - h) & SMASK;
                    pz = (z + SIDE - h) & SMASK;
                    corner = map_cells[cell_idx(x, z)];
                    centre = map_cells[cell_idx(mx, mz)];
                    lft = displace(corner, map_cells[cell_idx(x, nz)],
                                   map_cells[cell_idx(px, mz)], centre);
                    top = displace(corner, map_cells[cell_idx(nx, z)],
                                   centre, map_cells[cell_idx(mx, pz)]);
                    map_cells[cell_idx(mx, z)] = top;
                    map_cells[cell_idx(x, mz)] = lft;
                end
            amp = (amp * decay_reg) >> 16;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // one request; valid is lowered only when a gap comes before it
    task automatic send_request(logic cmd, logic [7:0] x, logic [7:0] z);
        int gap;
        height_result_t res;
        gap = quiet ? 0 : $urandom_range(0, 17);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_cell_x  <= x;
        s_cell_z  <= z;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        if (cmd == CMD_GENERATE) begin
            build_map();
            res.height = '0;
            res.done   = 1'b1;
        end else begin
            res.height = map_cells[cell_idx(x, z)][23:0];
            res.done   = 1'b0;
        end
        res.sat = clip;
        pending_results.push_back(res);
    endtask

    task automatic settle_and_config(bit [31:0] seed, bit [15:0] decay);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SEED;
        cfg_data  <= seed;
        @(negedge aclk);
        cfg_index <= REG_DECAY;
        cfg_data  <= {16'd0, decay};
        @(negedge aclk);
        cfg_we <= 1'b0;
        seed_reg  = seed;
        decay_reg = decay;
    endtask

    task automatic read_corners();
        send_request(CMD_READ, 8'd0, 8'd0);
        send_request(CMD_READ, 8'd255, 8'd255);
        send_request(CMD_READ, 8'd0, 8'd255);
        send_request(CMD_READ, 8'd255, 8'd0);
        send_request(CMD_READ, 8'd128, 8'd128);
    endtask

    task automatic test_default_map();
        send_request(CMD_GENERATE, 8'd0, 8'd0);
        read_corners();
        quiet = 1'b1;
        repeat (5) send_request(CMD_READ, 8'($urandom), 8'($urandom));
        quiet = 1'b0;
    endtask

    task automatic test_max_seed_no_decay();
        settle_and_config(32'hFFFF_FFFF, 16'd0);
        send_request(CMD_GENERATE, 8'hFF, 8'hFF);
        read_corners();
    endtask

    // zero seed falls back to one; near-unity decay keeps the amplitude up
    task automatic test_zero_seed_full_decay();
        settle_and_config(32'd0, 16'hFFFF);
        send_request(CMD_GENERATE, 8'h55, 8'hAA);
        read_corners();
    endtask

    task automatic test_random_reads();
        int i;
        settle_and_config($urandom_range(1, 32'hFFFF_FFFF), 16'($urandom));
        send_request(CMD_GENERATE, 8'($urandom), 8'($urandom));
        for (i = 0; i < 80; i++) begin
            if (i % 20 == 0) quiet = ($urandom_range(0, 2) == 0);
            send_request(CMD_READ, 8'($urandom), 8'($urandom));
        end
        quiet = 1'b0;
    endtask

    // result side: random stalls after each accepted result
    always @(negedge aclk) begin
        if (stall_left > 0 && !quiet) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        height_result_t want;
        if (m_valid && m_ready) begin
            stall_left = $urandom_range(0, 17);
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_height !== want.height) report_mismatch("height", m_height, want.height);
                if (m_generate_done !== want.done)
                    report_mismatch("generate_done", m_generate_done, want.done);
                if (m_saturated !== want.sat) report_mismatch("saturated", m_saturated, want.sat);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_count = 0;
        else idle_count++;
        if (idle_count >= WD_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_default_map();
        test_max_seed_no_decay();
        test_zero_seed_full_decay();
        test_random_reads();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
